### hdl/lcsf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcsf_pkg
// Shared types and codes for the LED color store with fade step.
// ----------------------------------------------------------------------------
package lcsf_pkg;

   localparam int COLOR_W = 8;
   localparam int ENTRY_W = 3 * COLOR_W;

   localparam logic [1:0] CMD_SET  = 2'd0;
   localparam logic [1:0] CMD_STEP = 2'd1;
   localparam logic [1:0] CMD_FILL = 2'd2;

   typedef enum logic [4:0] {
      ST_CLEAR  = 5'b00001,
      ST_IDLE   = 5'b00010,
      ST_MODIFY = 5'b00100,
      ST_FILL   = 5'b01000,
      ST_NULL   = 5'b10000
   } state_type;

   typedef struct packed {
      logic accept;
      logic sweep_write;
      logic sweep_zero;
      logic rmw_write;
      logic rsp_load;
      logic rsp_zero;
   } ctrl_cmd_type;

   typedef struct packed {
      logic req_fill;
      logic req_rmw;
      logic sweep_last;
      logic out_free;
   } dp_status_type;

endpackage
`default_nettype wire

### hdl/lcsf_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcsf_ctrl
// Sequencer: reset clear pass, per-item read-modify-write, fill sweep.
// ----------------------------------------------------------------------------
module lcsf_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire lcsf_pkg::dp_status_type status,
   output lcsf_pkg::ctrl_cmd_type      cmd
);

   lcsf_pkg::state_type state_ff;
   lcsf_pkg::state_type state_in;

   logic accept;

   assign req_ready = (state_ff == lcsf_pkg::ST_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.accept = accept;
      case (state_ff)
         lcsf_pkg::ST_CLEAR: begin
            cmd.sweep_write = 1'b1;
            cmd.sweep_zero  = 1'b1;
            if (status.sweep_last) begin
               state_in = lcsf_pkg::ST_IDLE;
            end
         end
         lcsf_pkg::ST_IDLE: begin
            if (accept) begin
               if (status.req_fill) begin
                  state_in = lcsf_pkg::ST_FILL;
               end else if (status.req_rmw) begin
                  state_in = lcsf_pkg::ST_MODIFY;
               end else begin
                  state_in = lcsf_pkg::ST_NULL;
               end
            end
         end
         lcsf_pkg::ST_MODIFY: begin
            if (status.out_free) begin
               cmd.rmw_write = 1'b1;
               cmd.rsp_load  = 1'b1;
               state_in      = lcsf_pkg::ST_IDLE;
            end
         end
         lcsf_pkg::ST_FILL: begin
            cmd.sweep_write = 1'b1;
            if (status.sweep_last && status.out_free) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_zero = 1'b1;
               state_in     = lcsf_pkg::ST_IDLE;
            end
         end
         lcsf_pkg::ST_NULL: begin
            if (status.out_free) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_zero = 1'b1;
               state_in     = lcsf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lcsf_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lcsf_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   a_sweep_done: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == lcsf_pkg::ST_FILL || state_ff == lcsf_pkg::ST_CLEAR)
       && state_in == lcsf_pkg::ST_IDLE) |-> status.sweep_last)
      else $error("sweep ended before last entry");

   a_rsp_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> status.out_free)
      else $error("result loaded over pending transfer");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != lcsf_pkg::ST_IDLE)
      else $error("accepted item did not start");

endmodule
`default_nettype wire

### hdl/lcsf_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcsf_dp
// Color memory, request registers, fade arithmetic and result register.
// ----------------------------------------------------------------------------
module lcsf_dp #(
   parameter int LED_COUNT = 64
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [1:0]                    req_command,
   input  wire logic [15:0]                   req_led_index,
   input  wire logic [lcsf_pkg::COLOR_W-1:0]  req_target_red,
   input  wire logic [lcsf_pkg::COLOR_W-1:0]  req_target_green,
   input  wire logic [lcsf_pkg::COLOR_W-1:0]  req_target_blue,
   input  wire logic [lcsf_pkg::COLOR_W-1:0]  req_step_size,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic                               rsp_changed,
   output logic                               rsp_index_ok,
   output logic [lcsf_pkg::COLOR_W-1:0]       rsp_new_red,
   output logic [lcsf_pkg::COLOR_W-1:0]       rsp_new_green,
   output logic [lcsf_pkg::COLOR_W-1:0]       rsp_new_blue,
   input  wire lcsf_pkg::ctrl_cmd_type        cmd,
   output lcsf_pkg::dp_status_type            status
);

   localparam int ADDR_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
   localparam int CW     = lcsf_pkg::COLOR_W;

   function automatic logic [CW-1:0] fade_chan(input logic [CW-1:0] cur,
                                               input logic [CW-1:0] tgt,
                                               input logic [CW-1:0] lim);
      logic [CW-1:0] gap;
      logic [CW-1:0] mv;
      gap = (tgt > cur) ? (tgt - cur) : (cur - tgt);
      mv  = (gap < lim) ? gap : lim;
      fade_chan = (tgt > cur) ? (cur + mv) : (cur - mv);
   endfunction

   logic [lcsf_pkg::ENTRY_W-1:0] mem [LED_COUNT];
   logic [lcsf_pkg::ENTRY_W-1:0] rdata_ff;

   logic              in_range;
   logic              step_ff;
   logic [ADDR_W-1:0] idx_ff;
   logic [CW-1:0]     red_ff, green_ff, blue_ff, lim_ff;
   logic [ADDR_W-1:0] sweep_addr_ff;
   logic              sweep_last;

   logic [CW-1:0] cur_red, cur_green, cur_blue;
   logic [CW-1:0] new_red, new_green, new_blue;
   logic          differ;

   logic                         we;
   logic [ADDR_W-1:0]            waddr;
   logic [lcsf_pkg::ENTRY_W-1:0] wdata;

   logic          rsp_valid_ff, rsp_valid_in;
   logic          changed_ff;
   logic          index_ok_ff;
   logic [CW-1:0] out_red_ff, out_green_ff, out_blue_ff;

   assign in_range   = (req_led_index < 16'(LED_COUNT))
                       && (req_command == lcsf_pkg::CMD_SET
                           || req_command == lcsf_pkg::CMD_STEP);
   assign sweep_last = (sweep_addr_ff == ADDR_W'(LED_COUNT - 1));

   assign status.req_fill   = (req_command == lcsf_pkg::CMD_FILL);
   assign status.req_rmw    = in_range;
   assign status.sweep_last = sweep_last;
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

   assign cur_red   = rdata_ff[3*CW-1:2*CW];
   assign cur_green = rdata_ff[2*CW-1:CW];
   assign cur_blue  = rdata_ff[CW-1:0];
   assign differ    = (cur_red != red_ff) || (cur_green != green_ff)
                      || (cur_blue != blue_ff);

   always_comb begin
      if (step_ff) begin
         new_red   = fade_chan(cur_red, red_ff, lim_ff);
         new_green = fade_chan(cur_green, green_ff, lim_ff);
         new_blue  = fade_chan(cur_blue, blue_ff, lim_ff);
      end else begin
         new_red   = red_ff;
         new_green = green_ff;
         new_blue  = blue_ff;
      end
   end

   always_comb begin
      we = cmd.sweep_write || cmd.rmw_write;
      if (cmd.sweep_write) begin
         waddr = sweep_addr_ff;
         wdata = cmd.sweep_zero ? '0 : {red_ff, green_ff, blue_ff};
      end else begin
         waddr = idx_ff;
         wdata = {new_red, new_green, new_blue};
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (cmd.accept && in_range) begin
         rdata_ff <= mem[req_led_index[ADDR_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         step_ff  <= (req_command == lcsf_pkg::CMD_STEP);
         idx_ff   <= req_led_index[ADDR_W-1:0];
         red_ff   <= req_target_red;
         green_ff <= req_target_green;
         blue_ff  <= req_target_blue;
         lim_ff   <= req_step_size;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_addr_ff <= '0;
      end else if (cmd.accept) begin
         sweep_addr_ff <= '0;
      end else if (cmd.sweep_write && !sweep_last) begin
         sweep_addr_ff <= sweep_addr_ff + ADDR_W'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         if (cmd.rsp_zero) begin
            changed_ff   <= 1'b0;
            index_ok_ff  <= 1'b0;
            out_red_ff   <= '0;
            out_green_ff <= '0;
            out_blue_ff  <= '0;
         end else begin
            changed_ff   <= step_ff && differ;
            index_ok_ff  <= 1'b1;
            out_red_ff   <= new_red;
            out_green_ff <= new_green;
            out_blue_ff  <= new_blue;
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_changed   = changed_ff;
   assign rsp_index_ok  = index_ok_ff;
   assign rsp_new_red   = out_red_ff;
   assign rsp_new_green = out_green_ff;
   assign rsp_new_blue  = out_blue_ff;

endmodule
`default_nettype wire

### hdl/led_color_store_with_fade_step_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// led_color_store_with_fade_step_top
// Per-LED RGB store with set, fill and fade step commands.
// ----------------------------------------------------------------------------
// After reset the block runs a clear pass that writes zero to all LED_COUNT
// entries, one per cycle, with req_ready low until the pass ends. Set and
// step read the entry from the color memory in the transfer cycle and write
// it back, with the result registered, once the result register is free. An
// index out of range or the unused command loads a zeroed result. Fill time
// is set by the one write port sweeping every entry. The result register
// lets a new item be taken while the previous result waits on rsp_ready.
module led_color_store_with_fade_step_top #(
   parameter int LED_COUNT = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_command,
   input  wire logic [15:0] req_led_index,
   input  wire logic [7:0]  req_target_red,
   input  wire logic [7:0]  req_target_green,
   input  wire logic [7:0]  req_target_blue,
   input  wire logic [7:0]  req_step_size,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_changed,
   output logic             rsp_index_ok,
   output logic [7:0]       rsp_new_red,
   output logic [7:0]       rsp_new_green,
   output logic [7:0]       rsp_new_blue
);

   lcsf_pkg::ctrl_cmd_type  cmd;
   lcsf_pkg::dp_status_type status;

   lcsf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   lcsf_dp #(
      .LED_COUNT (LED_COUNT)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_command      (req_command),
      .req_led_index    (req_led_index),
      .req_target_red   (req_target_red),
      .req_target_green (req_target_green),
      .req_target_blue  (req_target_blue),
      .req_step_size    (req_step_size),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_changed      (rsp_changed),
      .rsp_index_ok     (rsp_index_ok),
      .rsp_new_red      (rsp_new_red),
      .rsp_new_green    (rsp_new_green),
      .rsp_new_blue     (rsp_new_blue),
      .cmd              (cmd),
      .status           (status)
   );

endmodule
`default_nettype wire

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the LED color store with set, fill and fade step.
// ----------------------------------------------------------------------------
// A shadow copy of the color store is updated at every request transfer.
// Each request's expected response is queued at that point and compared
// field by field with each response transfer. Directed tests cover the
// cleared store, range limits, fades, fill and the unused command. Random
// traffic follows, with sender idling and receiver stalls in several
// mixes. Whole fades are run to convergence, and one long receiver
// hold-off fills the block while the sender keeps offering requests.
module testbench;

   localparam int LED_COUNT    = 64;
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int HOLD_CYCLES  = 250;
   localparam int QUIET_LIMIT  = 3000;
   localparam int TAIL_CYCLES  = 20;
   localparam int PRINT_LIMIT  = 40;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } color_type;

   typedef struct packed {
      logic      changed;
      logic      index_ok;
      color_type color;
   } led_result_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_command = lcsf_pkg::CMD_SET;
   logic [15:0] req_led_index = '0;
   logic [7:0]  req_target_red = '0;
   logic [7:0]  req_target_green = '0;
   logic [7:0]  req_target_blue = '0;
   logic [7:0]  req_step_size = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_changed;
   logic        rsp_index_ok;
   logic [7:0]  rsp_new_red;
   logic [7:0]  rsp_new_green;
   logic [7:0]  rsp_new_blue;

   color_type      led_shadow [LED_COUNT];
   led_result_type pending_results [$];
   int             error_count = 0;
   int             results_seen = 0;
   int             quiet_cycles = 0;
   int             sender_idle_pct = 0;
   int             receiver_stall_pct = 0;
   logic           rsp_hold = 1'b0;
   event           hold_start;

   led_color_store_with_fade_step_top #(
      .LED_COUNT(LED_COUNT)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_led_index   (req_led_index),
      .req_target_red  (req_target_red),
      .req_target_green(req_target_green),
      .req_target_blue (req_target_blue),
      .req_step_size   (req_step_size),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_changed     (rsp_changed),
      .rsp_index_ok    (rsp_index_ok),
      .rsp_new_red     (rsp_new_red),
      .rsp_new_green   (rsp_new_green),
      .rsp_new_blue    (rsp_new_blue)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [7:0] fade_toward(input logic [7:0] level, goal, limit);
      if (goal > level) begin
         return (goal - level < limit) ? goal : level + limit;
      end
      if (goal < level) begin
         return (level - goal < limit) ? goal : level - limit;
      end
      return level;
   endfunction

   function automatic led_result_type apply_led_command(input logic [1:0] command,
                                                        input logic [15:0] led,
                                                        input logic [7:0] red, green, blue,
                                                        input logic [7:0] step);
      led_result_type outcome;
      color_type      was;
      outcome = '0;
      if (command == lcsf_pkg::CMD_FILL) begin
         foreach (led_shadow[i]) led_shadow[i] = {red, green, blue};
      end else if ((command == lcsf_pkg::CMD_SET || command == lcsf_pkg::CMD_STEP)
                   && led < LED_COUNT) begin
         outcome.index_ok = 1'b1;
         if (command == lcsf_pkg::CMD_SET) begin
            led_shadow[led] = {red, green, blue};
         end else begin
            was = led_shadow[led];
            outcome.changed = (was != {red, green, blue});
            led_shadow[led] = {fade_toward(was.red, red, step),
                               fade_toward(was.green, green, step),
                               fade_toward(was.blue, blue, step)};
         end
         outcome.color = led_shadow[led];
      end
      return outcome;
   endfunction

   task automatic report_mismatch(input string note);
      if (error_count < PRINT_LIMIT) begin
         $display("[%0t] response %0d: %s", $realtime, results_seen, note);
      end
      error_count++;
   endtask

   // Valid stays high after a transfer unless a gap follows.
   task automatic send_item(input logic [1:0] command, input logic [15:0] led,
                            input logic [7:0] red, green, blue, input logic [7:0] step);
      int gap;
      gap = 0;
      while ($urandom_range(0, 99) < sender_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_command      <= command;
      req_led_index    <= led;
      req_target_red   <= red;
      req_target_green <= green;
      req_target_blue  <= blue;
      req_step_size    <= step;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_results.push_back(apply_led_command(command, led, red, green, blue, step));
   endtask

   task automatic send_random_item();
      int          pick;
      logic [1:0]  command;
      logic [15:0] led;
      logic [7:0]  step;
      pick = $urandom_range(0, 99);
      if (pick < 35) command = lcsf_pkg::CMD_SET;
      else if (pick < 89) command = lcsf_pkg::CMD_STEP;
      else if (pick < 94) command = lcsf_pkg::CMD_FILL;
      else command = CMD_UNUSED;
      if ($urandom_range(0, 9) == 0) led = 16'($urandom);
      else led = 16'($urandom_range(0, LED_COUNT - 1));
      if ($urandom_range(0, 1) == 1) step = 8'($urandom_range(0, 16));
      else step = 8'($urandom);
      send_item(command, led, 8'($urandom), 8'($urandom), 8'($urandom), step);
   endtask

   task automatic test_cleared_store();
      send_item(lcsf_pkg::CMD_STEP, 16'd0, 8'h00, 8'h00, 8'h00, 8'd0);
      send_item(lcsf_pkg::CMD_STEP, 16'(LED_COUNT - 1), 8'h00, 8'h00, 8'h00, 8'd255);
   endtask

   task automatic test_set_and_range();
      send_item(lcsf_pkg::CMD_SET, 16'd0, 8'hFF, 8'h00, 8'hFF, 8'd0);
      send_item(lcsf_pkg::CMD_SET, 16'(LED_COUNT - 1), 8'h00, 8'hFF, 8'h00, 8'd255);
      send_item(lcsf_pkg::CMD_SET, 16'(LED_COUNT), 8'hFF, 8'hFF, 8'hFF, 8'd0);
      send_item(lcsf_pkg::CMD_SET, 16'hFFFF, 8'hAA, 8'h55, 8'hAA, 8'hFF);
      send_item(lcsf_pkg::CMD_STEP, 16'd0, 8'hFF, 8'h00, 8'hFF, 8'd0);
   endtask

   task automatic test_fade_step();
      send_item(lcsf_pkg::CMD_STEP, 16'd0, 8'h00, 8'hFF, 8'h00, 8'd0);
      send_item(lcsf_pkg::CMD_STEP, 16'd0, 8'h00, 8'hFF, 8'h00, 8'd255);
      send_item(lcsf_pkg::CMD_STEP, 16'(LED_COUNT - 1), 8'h80, 8'h7F, 8'h01, 8'd7);
      send_item(lcsf_pkg::CMD_STEP, 16'(LED_COUNT - 1), 8'h80, 8'h7F, 8'h01, 8'd7);
      send_item(lcsf_pkg::CMD_STEP, 16'(LED_COUNT - 1), 8'h80, 8'h7F, 8'h01, 8'd255);
      send_item(lcsf_pkg::CMD_STEP, 16'(LED_COUNT - 1), 8'h80, 8'h7F, 8'h01, 8'd1);
      send_item(lcsf_pkg::CMD_STEP, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'd255);
      send_item(lcsf_pkg::CMD_STEP, 16'(LED_COUNT), 8'h00, 8'h00, 8'h00, 8'd255);
   endtask

   task automatic test_fill();
      send_item(lcsf_pkg::CMD_FILL, 16'd0, 8'hA5, 8'h5A, 8'hC3, 8'd0);
      send_item(lcsf_pkg::CMD_STEP, 16'd17, 8'hA5, 8'h5A, 8'hC3, 8'd3);
      send_item(lcsf_pkg::CMD_STEP, 16'd40, 8'h00, 8'h00, 8'h00, 8'd1);
      send_item(lcsf_pkg::CMD_FILL, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      send_item(lcsf_pkg::CMD_STEP, 16'd0, 8'h00, 8'h00, 8'h00, 8'd255);
   endtask

   task automatic test_unused_command();
      send_item(CMD_UNUSED, 16'd0, 8'h00, 8'h00, 8'h00, 8'hFF);
      send_item(CMD_UNUSED, 16'hFFFF, 8'h12, 8'h34, 8'h56, 8'd9);
      send_item(lcsf_pkg::CMD_STEP, 16'd0, 8'h00, 8'h00, 8'h00, 8'd0);
   endtask

   task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                      input int count);
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      repeat (count) send_random_item();
   endtask

   // Repeated steps on one LED toward one color until it stops changing.
   task automatic test_fade_sequences(input int count);
      logic [15:0] led;
      color_type   goal;
      logic [7:0]  rate;
      int          steps;
      sender_idle_pct    = 13;
      receiver_stall_pct = 13;
      repeat (count) begin
         led  = 16'($urandom_range(0, LED_COUNT - 1));
         goal = color_type'(24'($urandom));
         rate = 8'($urandom_range(4, 64));
         if ($urandom_range(0, 1) == 1) begin
            send_item(lcsf_pkg::CMD_SET, led, 8'($urandom), 8'($urandom), 8'($urandom),
                      8'd0);
         end
         steps = 0;
         while (led_shadow[led] != goal && steps < 80) begin
            send_item(lcsf_pkg::CMD_STEP, led, goal.red, goal.green, goal.blue, rate);
            steps++;
         end
         send_item(lcsf_pkg::CMD_STEP, led, goal.red, goal.green, goal.blue, rate);
      end
   endtask

   task automatic test_output_backpressure();
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      -> hold_start;
      repeat (30) send_random_item();
   endtask

   initial begin
      forever begin
         @(hold_start);
         rsp_hold <= 1'b1;
         repeat (HOLD_CYCLES) @(posedge clock);
         rsp_hold <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (rsp_hold) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
      end
   end

   always @(posedge clock) begin
      led_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("transfer with no response outstanding");
         end else begin
            want = pending_results.pop_front();
            if (rsp_changed !== want.changed)
               report_mismatch($sformatf("changed %b, expected %b", rsp_changed,
                                         want.changed));
            if (rsp_index_ok !== want.index_ok)
               report_mismatch($sformatf("index_ok %b, expected %b", rsp_index_ok,
                                         want.index_ok));
            if (rsp_new_red !== want.color.red)
               report_mismatch($sformatf("new_red %h, expected %h", rsp_new_red,
                                         want.color.red));
            if (rsp_new_green !== want.color.green)
               report_mismatch($sformatf("new_green %h, expected %h", rsp_new_green,
                                         want.color.green));
            if (rsp_new_blue !== want.color.blue)
               report_mismatch($sformatf("new_blue %h, expected %h", rsp_new_blue,
                                         want.color.blue));
         end
         results_seen++;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("led_color_store_with_fade_step_top test failed");
         $finish;
      end
   end

   initial begin
      foreach (led_shadow[i]) led_shadow[i] = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_cleared_store();
      test_set_and_range();
      test_fade_step();
      test_fill();
      test_unused_command();
      test_random_traffic(0, 0, 100);
      test_random_traffic(67, 0, 100);
      test_random_traffic(0, 67, 100);
      test_random_traffic(13, 13, 100);
      test_fade_sequences(12);
      test_output_backpressure();

      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("led_color_store_with_fade_step_top test passed");
      end else begin
         $display("led_color_store_with_fade_step_top test failed");
      end
      $finish;
   end

endmodule
